// ----- rtl/bhc_pkg.sv -----
// bhc_pkg: shared types and constants for the binaural hrir convolver
// request and result payload structs, op and ear codes, fixed field widths
// no dependencies
package bhc_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_BITS      = 16;
  localparam int TAP_INDEX_BITS = 9;

  localparam logic OP_TAP    = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic EAR_LEFT  = 1'b0;
  localparam logic EAR_RIGHT = 1'b1;

  typedef struct packed {
    logic                          op;
    logic                          ear;
    logic [TAP_INDEX_BITS-1:0]     tap_index;
    logic signed [COEF_BITS-1:0]   tap_value;
    logic signed [SAMPLE_BITS-1:0] sample;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
  } result_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TAP_RD,
    ST_TAP_WR,
    ST_MAC,
    ST_DRAIN
  } state_t;

endpackage

// ----- rtl/bhc_ram.sv -----
// bhc_ram: generic simple dual-port ram, one write port and one read port
// read data registered, no reset on contents
// no dependencies
module bhc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/binaural_hrir_convolver_unit.sv -----
// sample request: TAPS mac reads of the history and tap rams, then the read data,
// product and accumulator registers, then round/saturate into the result register
// tap load request: read-modify-write of the shared tap ram word
// one request in flight; the next is taken while a result waits on stall
// after reset a clearing pass over all TAPS addresses zeroes taps and history, no
// request is taken during it
module binaural_hrir_convolver_unit import bhc_pkg::*; #(
  parameter int TAPS = 512
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int ADDR_W = $clog2(TAPS);
  localparam int CNT_W  = $clog2(TAPS + 1);
  localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W  = PROD_W + $clog2(TAPS);
  localparam int SHIFT  = COEF_BITS - 2;
  localparam logic [ADDR_W-1:0] LAST = ADDR_W'(TAPS - 1);
  localparam logic signed [ACC_W:0] RND     = (ACC_W + 1)'(1) <<< (SHIFT - 1);
  localparam logic signed [ACC_W:0] SAT_MAX = (ACC_W + 1)'((2 ** (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ACC_W:0] SAT_MIN = ~SAT_MAX;

  state_t state, state_next;
  item_t  req;

  logic [ADDR_W-1:0] k, pos, wp;
  logic [CNT_W-1:0]  warm;
  logic              rdv, prodv;
  logic signed [PROD_W-1:0] prod_l, prod_r;
  logic signed [ACC_W-1:0]  acc_l, acc_r;

  logic                   tap_we;
  logic [ADDR_W-1:0]      tap_waddr, tap_raddr;
  logic [2*COEF_BITS-1:0] tap_wdata, tap_rdata;
  logic                   hist_we;
  logic [ADDR_W-1:0]      hist_waddr;
  logic [SAMPLE_BITS-1:0] hist_wdata, hist_rdata;

  logic accept, idx_ok, pipe_empty, warm_done, out_free, finish, load_out;

  function automatic logic [SAMPLE_BITS-1:0] sat_out(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W:0] r;
    r = (ACC_W + 1)'(a) + RND;
    r = r >>> SHIFT;
    if (r > SAT_MAX) begin
      sat_out = SAT_MAX[SAMPLE_BITS-1:0];
    end else if (r < SAT_MIN) begin
      sat_out = SAT_MIN[SAMPLE_BITS-1:0];
    end else begin
      sat_out = r[SAMPLE_BITS-1:0];
    end
  endfunction

  assign accept     = item_valid && !item_stall;
  assign idx_ok     = 32'(req.tap_index) < 32'(TAPS);
  assign pipe_empty = !rdv && !prodv;
  assign warm_done  = warm == CNT_W'(TAPS);
  assign out_free   = !result_valid || !result_stall;

  bhc_ram #(.WIDTH(2 * COEF_BITS), .DEPTH(TAPS)) u_tap_ram (
    .clk   (clk),
    .we    (tap_we),
    .waddr (tap_waddr),
    .wdata (tap_wdata),
    .raddr (tap_raddr),
    .rdata (tap_rdata)
  );

  bhc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(TAPS)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (pos),
    .rdata (hist_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item_stall = 1'b1;
    tap_we     = 1'b0;
    tap_waddr  = k;
    tap_wdata  = '0;
    tap_raddr  = k;
    hist_we    = 1'b0;
    hist_waddr = wp;
    hist_wdata = item.sample;
    finish     = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_CLEAR: begin
        tap_we     = 1'b1;
        hist_we    = 1'b1;
        hist_waddr = k;
        hist_wdata = '0;
        if (k == LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          if (item.op == OP_SAMPLE) begin
            hist_we    = 1'b1;
            state_next = ST_MAC;
          end else begin
            state_next = ST_TAP_RD;
          end
        end
      end
      ST_TAP_RD: begin
        tap_raddr  = ADDR_W'(req.tap_index);
        state_next = ST_TAP_WR;
      end
      ST_TAP_WR: begin
        tap_we    = idx_ok;
        tap_waddr = ADDR_W'(req.tap_index);
        if (req.ear == EAR_RIGHT) begin
          tap_wdata = {req.tap_value, tap_rdata[COEF_BITS-1:0]};
        end else begin
          tap_wdata = {tap_rdata[2*COEF_BITS-1:COEF_BITS], req.tap_value};
        end
        state_next = ST_IDLE;
      end
      ST_MAC: begin
        if (k == LAST) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pipe_empty) begin
          if (!warm_done) begin
            finish     = 1'b1;
            state_next = ST_IDLE;
          end else if (out_free) begin
            finish     = 1'b1;
            load_out   = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k            <= '0;
      pos          <= '0;
      wp           <= '0;
      warm         <= '0;
      rdv          <= 1'b0;
      prodv        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      rdv   <= state == ST_MAC;
      prodv <= rdv;
      if (state == ST_CLEAR || state == ST_MAC) begin
        k <= (k == LAST) ? '0 : k + 1'b1;
      end
      if (accept) begin
        pos <= wp;
      end else if (state == ST_MAC) begin
        pos <= (pos == '0) ? LAST : pos - 1'b1;
      end
      if (finish) begin
        wp <= (wp == LAST) ? '0 : wp + 1'b1;
        if (!warm_done) begin
          warm <= warm + 1'b1;
        end
      end
      if (load_out) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req <= item;
    end
    prod_l <= $signed(hist_rdata) * $signed(tap_rdata[COEF_BITS-1:0]);
    prod_r <= $signed(hist_rdata) * $signed(tap_rdata[2*COEF_BITS-1:COEF_BITS]);
    if (accept) begin
      acc_l <= '0;
      acc_r <= '0;
    end else if (prodv) begin
      acc_l <= acc_l + ACC_W'(prod_l);
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (load_out) begin
      result.left_out  <= sat_out(acc_l);
      result.right_out <= sat_out(acc_r);
    end
  end

endmodule

// ----- rtl/bhc_checker.sv -----
// bhc_checker: port-level assertions for binaural_hrir_convolver_unit
// bound to the top level at the end of this file; uses bhc_pkg
module bhc_checker import bhc_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_stall,
  input item_t   item,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> item_stall)
    else $error("request taken during clearing pass");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("request taken back to back");

  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && item.op == OP_SAMPLE |-> ##3 item_stall)
    else $error("sample request finished too early");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(item_stall))
    else $error("result without a sample in progress");

endmodule

bind binaural_hrir_convolver_unit bhc_checker u_bhc_checker (.*);

// ----- verif/tb_binaural_hrir_convolver_unit.sv -----
// tb_binaural_hrir_convolver_unit: self-checking bench for the stereo hrir fir unit
// predicts both ear outputs per sample request from its own tap and history copies
// depends on bhc_pkg and binaural_hrir_convolver_unit
module tb_binaural_hrir_convolver_unit import bhc_pkg::*; ();

  localparam int TAPS       = 512;
  localparam int IDLE_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 830;

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_stall;
  item_t   item;
  logic    result_valid;
  logic    result_stall;
  result_t result;

  logic signed [COEF_BITS-1:0]   left_taps [TAPS] = '{default: '0};
  logic signed [COEF_BITS-1:0]   right_taps [TAPS] = '{default: '0};
  logic signed [SAMPLE_BITS-1:0] mono_history [TAPS] = '{default: '0};
  int      hist_wr = 0;
  int      warm_count = 0;

  result_t expected_outputs [$];
  int      error_count = 0;
  int      stall_left = 0;
  int      idle_cycles = 0;
  bit      idle_on = 1'b0;

  binaural_hrir_convolver_unit #(.TAPS(TAPS)) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic signed [SAMPLE_BITS-1:0] round_saturate(input longint acc);
    longint scaled;
    longint hi_lim;
    longint lo_lim;
    hi_lim = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    lo_lim = -(longint'(1) <<< (SAMPLE_BITS - 1));
    // gain 2 and back to q1.15, ties toward plus infinity
    scaled = (acc + (longint'(1) <<< (COEF_BITS - 3))) >>> (COEF_BITS - 2);
    if (scaled > hi_lim) begin
      scaled = hi_lim;
    end else if (scaled < lo_lim) begin
      scaled = lo_lim;
    end
    return scaled[SAMPLE_BITS-1:0];
  endfunction

  function automatic void predict_stereo(input item_t r);
    longint  acc_left;
    longint  acc_right;
    int      pos;
    result_t want;
    if (r.op == OP_TAP) begin
      if (r.tap_index < TAPS) begin
        if (r.ear == EAR_LEFT) begin
          left_taps[r.tap_index] = r.tap_value;
        end else begin
          right_taps[r.tap_index] = r.tap_value;
        end
      end
      return;
    end
    mono_history[hist_wr] = r.sample;
    acc_left = 0;
    acc_right = 0;
    pos = hist_wr;
    for (int k = 0; k < TAPS; k++) begin
      acc_left += longint'(mono_history[pos]) * longint'(left_taps[k]);
      acc_right += longint'(mono_history[pos]) * longint'(right_taps[k]);
      pos = (pos == 0) ? TAPS - 1 : pos - 1;
    end
    hist_wr = (hist_wr + 1 >= TAPS) ? 0 : hist_wr + 1;
    // history still filling, nothing comes out
    if (warm_count < TAPS) begin
      warm_count++;
      return;
    end
    want.left_out = round_saturate(acc_left);
    want.right_out = round_saturate(acc_right);
    expected_outputs.push_back(want);
  endfunction

  function automatic item_t tap_request(input logic ear, input int idx,
                                        input logic signed [COEF_BITS-1:0] value);
    item_t r;
    r.op = OP_TAP;
    r.ear = ear;
    r.tap_index = TAP_INDEX_BITS'(idx);
    r.tap_value = value;
    r.sample = SAMPLE_BITS'($urandom);
    return r;
  endfunction

  function automatic item_t sample_request(input logic signed [SAMPLE_BITS-1:0] value);
    item_t r;
    r.op = OP_SAMPLE;
    r.ear = $urandom_range(0, 1) ? EAR_RIGHT : EAR_LEFT;
    r.tap_index = TAP_INDEX_BITS'($urandom);
    r.tap_value = COEF_BITS'($urandom);
    r.sample = value;
    return r;
  endfunction

  function automatic item_t random_request();
    item_t r;
    r.op = ($urandom_range(0, 9) < 7) ? OP_SAMPLE : OP_TAP;
    r.ear = $urandom_range(0, 1) ? EAR_RIGHT : EAR_LEFT;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: r.tap_index = TAP_INDEX_BITS'($urandom_range(0, 15));
      5, 6:          r.tap_index = TAP_INDEX_BITS'($urandom_range(TAPS - 16, TAPS - 1));
      default:       r.tap_index = TAP_INDEX_BITS'($urandom_range(0, TAPS - 1));
    endcase
    // many zero and small taps so that outputs do not all clip
    case ($urandom_range(0, 9))
      0, 1, 2, 3: r.tap_value = '0;
      4, 5, 6:    r.tap_value = COEF_BITS'($urandom_range(0, 1023) - 512);
      7:          r.tap_value = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default:    r.tap_value = COEF_BITS'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0:       r.sample = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1:       r.sample = SAMPLE_BITS'($urandom_range(0, 127) - 64);
      default: r.sample = SAMPLE_BITS'($urandom);
    endcase
    return r;
  endfunction

  task automatic send_request(input item_t r);
    int gap;
    gap = idle_on ? $urandom_range(0, 19) : 0;
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item <= r;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predict_stereo(r);
    @(negedge clk);
  endtask

  task automatic test_tap_extremes();
    idle_on = 1'b0;
    send_request(tap_request(EAR_LEFT, 0, 16'sh7fff));
    send_request(tap_request(EAR_RIGHT, 0, 16'sh8000));
    send_request(tap_request(EAR_LEFT, TAPS - 1, 16'sh8000));
    send_request(tap_request(EAR_RIGHT, TAPS - 1, 16'sh7fff));
    send_request(tap_request(EAR_LEFT, 1, 16'sh4000));
    send_request(tap_request(EAR_RIGHT, 2, 16'shffff));
  endtask

  task automatic test_tap_overwrite();
    idle_on = 1'b1;
    send_request(tap_request(EAR_LEFT, 1, 16'sh0000));
    send_request(tap_request(EAR_RIGHT, 2, 16'sh0001));
    send_request(tap_request(EAR_LEFT, 1, 16'sh4000));
  endtask

  task automatic test_warmup_samples();
    idle_on = 1'b1;
    send_request(sample_request(16'sh7fff));
    send_request(sample_request(16'sh8000));
    send_request(sample_request(16'sh0000));
    send_request(sample_request(16'shffff));
    send_request(sample_request(16'sh0001));
    send_request(sample_request(16'sh4000));
    send_request(sample_request(16'shc000));
    send_request(tap_request(EAR_RIGHT, 3, 16'sh2000));
    send_request(sample_request(16'sh7fff));
  endtask

  task automatic test_random_traffic();
    int sent;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent % 64 == 0) begin
        idle_on = ($urandom_range(0, 3) != 0);
      end
      send_request(random_request());
      sent++;
    end
  endtask

  task automatic test_drain();
    item_valid <= 1'b0;
    while (expected_outputs.size() != 0) @(posedge clk);
    repeat (TAPS + 8) @(posedge clk);
  endtask

  // receiver side back-pressure, counted down only while a result is offered
  always @(posedge clk) begin
    if (rst) begin
      stall_left <= 0;
    end else if (result_valid) begin
      if (result_stall) begin
        if (stall_left > 0) begin
          stall_left <= stall_left - 1;
        end
      end else begin
        stall_left <= idle_on ? int'($urandom_range(0, 19)) : 0;
      end
    end
  end

  always @(negedge clk) begin
    result_stall <= (stall_left != 0);
  end

  always @(posedge clk) begin : check_outputs
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_outputs.size() == 0) begin
        $error("output with no sample request pending: left %0d right %0d",
               result.left_out, result.right_out);
        error_count++;
      end else begin
        want = expected_outputs.pop_front();
        if (result.left_out !== want.left_out) begin
          $error("left_out expected %0d actual %0d", want.left_out, result.left_out);
          error_count++;
        end
        if (result.right_out !== want.right_out) begin
          $error("right_out expected %0d actual %0d", want.right_out, result.right_out);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_tap_extremes();
    test_tap_overwrite();
    test_warmup_samples();
    test_random_traffic();
    test_drain();
    if (error_count == 0 && expected_outputs.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
